// File: rtl/gcd_pkg.sv
// ----------------------------------------------------------------------------
// gcd_pkg
// Shared types and constants of the graph core decomposition block.
// ----------------------------------------------------------------------------
`default_nettype none

package gcd_pkg;

    localparam int MAX_NODES_DEF = 1024;
    localparam int MAX_EDGES_DEF = 4096;

    localparam int NODE_W      = 10;
    localparam int CORE_W      = 13;
    localparam int CFG_W       = 11;
    localparam int IN_DATA_W   = 24;
    localparam int OUT_DATA_W  = 24;

    localparam logic [CFG_W-1:0] NODE_COUNT_RST = 11'd1024;

    typedef enum logic [1:0] {
        REQ_ADD_EDGE = 2'd0,
        REQ_RUN      = 2'd1,
        REQ_READ     = 2'd2,
        REQ_CLEAR    = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        STS_OK    = 2'd0,
        STS_FULL  = 2'd1,
        STS_RANGE = 2'd2,
        STS_SELF  = 2'd3
    } t_status;

    // handshake between the front end and the peeling engine
    typedef struct packed {
        logic start;
        logic res_ready;
    } t_run_ctl;

endpackage

`default_nettype wire

// File: rtl/graph_core_decomposition.sv
// ----------------------------------------------------------------------------
// graph_core_decomposition
// Loads an undirected multigraph edge by edge, computes each node's coreness
// by bin-sort peeling and reads coreness values back.
//
// Requests enter on s_axis (tuser: request kind, tdata: node_a, node_b);
// every request gives exactly one result on m_axis (tuser: status,
// tdata: node_index, core_value). node_count is written through i_cfg_we.
// Add edge, read and clear take one transfer per cycle while s_axis_tready
// is high; the result passes through a stage register and the output
// register. A run request walks the graph in the peeling engine, one memory
// access step per cycle, each working memory having a single read port; no
// request is taken while it runs. Reset empties the graph, clears coreness
// and sets node_count to 1024; memory contents need no clearing pass. When
// m_axis stalls, one result waits in the output register and one more in
// the stage before it, then s_axis_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module graph_core_decomposition #(
    parameter int MAX_NODES = gcd_pkg::MAX_NODES_DEF,
    parameter int MAX_EDGES = gcd_pkg::MAX_EDGES_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [gcd_pkg::CFG_W-1:0]       i_cfg_wdata,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [gcd_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // node_a, node_b, pad
    input  wire logic [1:0]                      s_axis_tuser,  // req_type
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic      [gcd_pkg::OUT_DATA_W-1:0]  m_axis_tdata,  // node_index, core_value, pad
    output logic      [1:0]                      m_axis_tuser   // status
);

    import gcd_pkg::*;

    localparam int NODE_AW = $clog2(MAX_NODES);
    localparam int NCNT_W  = $clog2(MAX_NODES + 1);
    localparam int EDGE_AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ECNT_W  = $clog2(MAX_EDGES + 1);
    localparam int CMP_W   = (NCNT_W > CFG_W) ? NCNT_W : CFG_W;

    logic [CFG_W-1:0]  r_node_count;
    logic [ECNT_W-1:0] r_edge_total;
    logic              r_run_busy;
    logic              r_core_valid;
    logic [NCNT_W-1:0] r_core_n;

    logic              r_s1_valid, r_s1_mem;
    t_status           r_s1_status;
    logic [NODE_W-1:0] r_s1_idx;
    logic [CORE_W-1:0] r_s1_core;

    logic              r_out_valid;
    t_status           r_out_status;
    logic [NODE_W-1:0] r_out_idx;
    logic [CORE_W-1:0] r_out_core;

    t_req              req;
    logic [NODE_W-1:0] node_a, node_b;
    logic [NCNT_W-1:0] n_eff;
    logic              a_oor, b_oor, accept, out_free, slot_free;
    logic              eng_done;
    logic [ECNT_W-1:0] eng_top, core_rdata;
    t_run_ctl          run_ctl;
    logic              edge_we;
    t_status           in_status;

    assign req    = t_req'(s_axis_tuser);
    assign node_a = s_axis_tdata[NODE_W-1:0];
    assign node_b = s_axis_tdata[2*NODE_W-1:NODE_W];

    // nodes in use, saturated at the store size
    assign n_eff = (CMP_W'(r_node_count) > CMP_W'(MAX_NODES)) ? NCNT_W'(MAX_NODES)
                                                              : NCNT_W'(r_node_count);
    assign a_oor = CMP_W'(node_a) >= CMP_W'(n_eff);
    assign b_oor = CMP_W'(node_b) >= CMP_W'(n_eff);

    assign out_free      = !r_out_valid || m_axis_tready;
    assign slot_free     = !r_s1_valid || out_free;
    assign s_axis_tready = !r_run_busy && slot_free;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        in_status = STS_OK;
        edge_we   = 1'b0;
        priority if (req == REQ_ADD_EDGE) begin
            priority if (a_oor || b_oor) begin
                in_status = STS_RANGE;
            end else if (node_a == node_b) begin
                in_status = STS_SELF;
            end else if (r_edge_total == ECNT_W'(MAX_EDGES)) begin
                in_status = STS_FULL;
            end else begin
                edge_we = accept;
            end
        end else if (req == REQ_READ) begin
            if (a_oor) begin
                in_status = STS_RANGE;
            end
        end else begin
            in_status = STS_OK;
        end
    end

    assign run_ctl.start     = accept && (req == REQ_RUN);
    assign run_ctl.res_ready = slot_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= NODE_COUNT_RST;
            r_edge_total <= '0;
            r_run_busy   <= 1'b0;
            r_core_valid <= 1'b0;
            r_core_n     <= '0;
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_node_count <= i_cfg_wdata;
            end

            if (out_free) begin
                r_out_valid <= r_s1_valid;
            end
            if (r_s1_valid && out_free) begin
                r_out_status <= r_s1_status;
                r_out_idx    <= r_s1_idx;
                r_out_core   <= r_s1_mem ? CORE_W'(core_rdata) : r_s1_core;
            end

            if (accept) begin
                r_s1_valid  <= (req != REQ_RUN);
                r_s1_status <= in_status;
                r_s1_idx    <= (req == REQ_READ) ? node_a : '0;
                r_s1_core   <= '0;
                r_s1_mem    <= (req == REQ_READ) && !a_oor && r_core_valid
                               && (CMP_W'(node_a) < CMP_W'(r_core_n));
                unique case (req)
                    REQ_ADD_EDGE: begin
                        if (edge_we) begin
                            r_edge_total <= r_edge_total + 1'b1;
                        end
                    end
                    REQ_RUN: begin
                        r_run_busy   <= 1'b1;
                        r_core_valid <= 1'b1;
                        r_core_n     <= n_eff;
                    end
                    REQ_READ: begin
                    end
                    REQ_CLEAR: begin
                        r_edge_total <= '0;
                        r_core_valid <= 1'b0;
                    end
                    default: begin
                    end
                endcase
            end else if (eng_done && slot_free) begin
                // run result takes the free stage
                r_run_busy  <= 1'b0;
                r_s1_valid  <= 1'b1;
                r_s1_status <= STS_OK;
                r_s1_idx    <= '0;
                r_s1_core   <= CORE_W'(eng_top);
                r_s1_mem    <= 1'b0;
            end else if (slot_free) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    gcd_engine #(
        .MAX_NODES(MAX_NODES),
        .MAX_EDGES(MAX_EDGES),
        .NODE_AW  (NODE_AW),
        .NCNT_W   (NCNT_W),
        .EDGE_AW  (EDGE_AW),
        .ECNT_W   (ECNT_W)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (run_ctl),
        .i_n          (n_eff),
        .i_edge_total (r_edge_total),
        .i_edge_we    (edge_we),
        .i_edge_waddr (r_edge_total[EDGE_AW-1:0]),
        .i_edge_wdata ({NODE_AW'(node_b), NODE_AW'(node_a)}),
        .i_core_re    (accept && (req == REQ_READ)),
        .i_core_raddr (NODE_AW'(node_a)),
        .o_core_rdata (core_rdata),
        .o_done       (eng_done),
        .o_top        (eng_top)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = {(OUT_DATA_W - NODE_W - CORE_W)'(0), r_out_core, r_out_idx};

endmodule

`default_nettype wire

// File: rtl/gcd_ram.sv
// ----------------------------------------------------------------------------
// gcd_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module gcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/gcd_engine.sv
// ----------------------------------------------------------------------------
// gcd_engine
// Edge store, adjacency build and bin-sort peeling over on-chip memories.
// ----------------------------------------------------------------------------
`default_nettype none

module gcd_engine #(
    parameter int MAX_NODES = gcd_pkg::MAX_NODES_DEF,
    parameter int MAX_EDGES = gcd_pkg::MAX_EDGES_DEF,
    parameter int NODE_AW   = $clog2(MAX_NODES),
    parameter int NCNT_W    = $clog2(MAX_NODES + 1),
    parameter int EDGE_AW   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1,
    parameter int ECNT_W    = $clog2(MAX_EDGES + 1)
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire gcd_pkg::t_run_ctl       i_ctl,
    input  wire logic [NCNT_W-1:0]       i_n,
    input  wire logic [ECNT_W-1:0]       i_edge_total,
    input  wire logic                    i_edge_we,
    input  wire logic [EDGE_AW-1:0]      i_edge_waddr,
    input  wire logic [2*NODE_AW-1:0]    i_edge_wdata,
    input  wire logic                    i_core_re,
    input  wire logic [NODE_AW-1:0]      i_core_raddr,
    output logic      [ECNT_W-1:0]       o_core_rdata,
    output logic                         o_done,
    output logic      [ECNT_W-1:0]       o_top
);

    import gcd_pkg::*;

    localparam int DEG_W  = ECNT_W;
    localparam int AS_W   = $clog2(2 * MAX_EDGES + 1);
    localparam int ADJ_AW = $clog2(2 * MAX_EDGES);
    localparam int ACC_W  = (AS_W > NCNT_W) ? AS_W : NCNT_W;
    localparam int ST_W   = 32;

    typedef enum logic [ST_W-1:0] {
        S_IDLE   = ST_W'(1) << 0,
        S_DCLR   = ST_W'(1) << 1,
        S_EW_RD  = ST_W'(1) << 2,
        S_EW_CHK = ST_W'(1) << 3,
        S_EW_A   = ST_W'(1) << 4,
        S_EW_B   = ST_W'(1) << 5,
        S_PF_RD  = ST_W'(1) << 6,
        S_PF_WR  = ST_W'(1) << 7,
        S_BCLR   = ST_W'(1) << 8,
        S_BC_RD  = ST_W'(1) << 9,
        S_BC_B   = ST_W'(1) << 10,
        S_BC_W   = ST_W'(1) << 11,
        S_BS_RD  = ST_W'(1) << 12,
        S_BS_WR  = ST_W'(1) << 13,
        S_PL_RD  = ST_W'(1) << 14,
        S_PL_B   = ST_W'(1) << 15,
        S_PL_W   = ST_W'(1) << 16,
        S_SH_RD  = ST_W'(1) << 17,
        S_SH_WR  = ST_W'(1) << 18,
        S_PE_U   = ST_W'(1) << 19,
        S_PE_D   = ST_W'(1) << 20,
        S_PE_S   = ST_W'(1) << 21,
        S_PE_E   = ST_W'(1) << 22,
        S_PE_K   = ST_W'(1) << 23,
        S_PE_W   = ST_W'(1) << 24,
        S_PE_C   = ST_W'(1) << 25,
        S_PE_X   = ST_W'(1) << 26,
        S_PE_M   = ST_W'(1) << 27,
        S_PE_N   = ST_W'(1) << 28,
        S_OUT_RD = ST_W'(1) << 29,
        S_OUT_WR = ST_W'(1) << 30,
        S_FIN    = ST_W'(1) << 31
    } t_state;

    t_state r_state;

    logic [NCNT_W-1:0]  r_n, r_v, r_pf;
    logic [ECNT_W-1:0]  r_et, r_e;
    logic [DEG_W-1:0]   r_d, r_maxdeg, r_top, r_du, r_dw;
    logic [AS_W-1:0]    r_k, r_kend;
    logic [ACC_W-1:0]   r_acc;
    logic               r_mode;     // 0: degree count walk, 1: adjacency fill walk
    logic [NODE_AW-1:0] r_a, r_b, r_u, r_w, r_pw, r_x;

    // memory ports
    logic                  edg_re;
    logic [EDGE_AW-1:0]    edg_raddr;
    logic [2*NODE_AW-1:0]  edg_rdata;

    logic                  deg_we, deg_re;
    logic [NODE_AW-1:0]    deg_waddr, deg_raddr;
    logic [DEG_W-1:0]      deg_wdata, deg_rdata;

    logic                  ast_we, ast_re;
    logic [NCNT_W-1:0]     ast_waddr, ast_raddr;
    logic [AS_W-1:0]       ast_wdata, ast_rdata;

    logic                  fil_we, fil_re;
    logic [NODE_AW-1:0]    fil_waddr, fil_raddr;
    logic [AS_W-1:0]       fil_wdata, fil_rdata;

    logic                  adj_we, adj_re;
    logic [ADJ_AW-1:0]     adj_waddr, adj_raddr;
    logic [NODE_AW-1:0]    adj_wdata, adj_rdata;

    logic                  ord_we, ord_re;
    logic [NODE_AW-1:0]    ord_waddr, ord_raddr;
    logic [NODE_AW-1:0]    ord_wdata, ord_rdata;

    logic                  pos_we, pos_re;
    logic [NODE_AW-1:0]    pos_waddr, pos_raddr;
    logic [NODE_AW-1:0]    pos_wdata, pos_rdata;

    logic                  bkt_we, bkt_re;
    logic [DEG_W-1:0]      bkt_waddr, bkt_raddr;
    logic [NCNT_W-1:0]     bkt_wdata, bkt_rdata;

    logic                  cor_we;
    logic [NODE_AW-1:0]    cor_waddr;
    logic [DEG_W-1:0]      cor_wdata;

    logic [NODE_AW-1:0]    ea, eb;
    logic                  e_ok;

    assign ea   = edg_rdata[NODE_AW-1:0];
    assign eb   = edg_rdata[2*NODE_AW-1:NODE_AW];
    assign e_ok = (NCNT_W'(ea) < r_n) && (NCNT_W'(eb) < r_n) && (ea != eb);

    assign o_done = (r_state == S_FIN);
    assign o_top  = r_top;

    always_comb begin
        edg_re = 1'b0; edg_raddr = r_e[EDGE_AW-1:0];
        deg_we = 1'b0; deg_waddr = '0; deg_wdata = '0; deg_re = 1'b0; deg_raddr = '0;
        ast_we = 1'b0; ast_waddr = '0; ast_wdata = '0; ast_re = 1'b0; ast_raddr = '0;
        fil_we = 1'b0; fil_waddr = '0; fil_wdata = '0; fil_re = 1'b0; fil_raddr = '0;
        adj_we = 1'b0; adj_waddr = '0; adj_wdata = '0; adj_re = 1'b0; adj_raddr = '0;
        ord_we = 1'b0; ord_waddr = '0; ord_wdata = '0; ord_re = 1'b0; ord_raddr = '0;
        pos_we = 1'b0; pos_waddr = '0; pos_wdata = '0; pos_re = 1'b0; pos_raddr = '0;
        bkt_we = 1'b0; bkt_waddr = '0; bkt_wdata = '0; bkt_re = 1'b0; bkt_raddr = '0;
        cor_we = 1'b0; cor_waddr = '0; cor_wdata = '0;
        unique case (r_state)
            S_DCLR: begin
                if (r_v != r_n) begin
                    deg_we    = 1'b1;
                    deg_waddr = r_v[NODE_AW-1:0];
                end
            end
            S_EW_RD: begin
                edg_re = (r_e != r_et);
            end
            S_EW_CHK: begin
                deg_re    = e_ok && !r_mode;
                deg_raddr = ea;
                fil_re    = e_ok && r_mode;
                fil_raddr = ea;
            end
            S_EW_A: begin
                if (!r_mode) begin
                    deg_we    = 1'b1;
                    deg_waddr = r_a;
                    deg_wdata = deg_rdata + 1'b1;
                    deg_re    = 1'b1;
                    deg_raddr = r_b;
                end else begin
                    adj_we    = 1'b1;
                    adj_waddr = fil_rdata[ADJ_AW-1:0];
                    adj_wdata = r_b;
                    fil_we    = 1'b1;
                    fil_waddr = r_a;
                    fil_wdata = fil_rdata + 1'b1;
                    fil_re    = 1'b1;
                    fil_raddr = r_b;
                end
            end
            S_EW_B: begin
                if (!r_mode) begin
                    deg_we    = 1'b1;
                    deg_waddr = r_b;
                    deg_wdata = deg_rdata + 1'b1;
                end else begin
                    adj_we    = 1'b1;
                    adj_waddr = fil_rdata[ADJ_AW-1:0];
                    adj_wdata = r_a;
                    fil_we    = 1'b1;
                    fil_waddr = r_b;
                    fil_wdata = fil_rdata + 1'b1;
                end
            end
            S_PF_RD: begin
                if (r_v == r_n) begin
                    ast_we    = 1'b1;
                    ast_waddr = r_n;
                    ast_wdata = AS_W'(r_acc);
                end else begin
                    deg_re    = 1'b1;
                    deg_raddr = r_v[NODE_AW-1:0];
                end
            end
            S_PF_WR: begin
                ast_we    = 1'b1;
                ast_waddr = r_v;
                ast_wdata = AS_W'(r_acc);
                fil_we    = 1'b1;
                fil_waddr = r_v[NODE_AW-1:0];
                fil_wdata = AS_W'(r_acc);
            end
            S_BCLR: begin
                bkt_we    = 1'b1;
                bkt_waddr = r_d;
            end
            S_BC_RD, S_PL_RD, S_OUT_RD: begin
                deg_re    = (r_v != r_n);
                deg_raddr = r_v[NODE_AW-1:0];
            end
            S_BC_B, S_PL_B: begin
                bkt_re    = 1'b1;
                bkt_raddr = deg_rdata;
            end
            S_BC_W: begin
                bkt_we    = 1'b1;
                bkt_waddr = r_dw;
                bkt_wdata = bkt_rdata + 1'b1;
            end
            S_BS_RD: begin
                bkt_re    = 1'b1;
                bkt_raddr = r_d;
            end
            S_BS_WR: begin
                bkt_we    = 1'b1;
                bkt_waddr = r_d;
                bkt_wdata = NCNT_W'(r_acc);
            end
            S_PL_W: begin
                pos_we    = 1'b1;
                pos_waddr = r_v[NODE_AW-1:0];
                pos_wdata = bkt_rdata[NODE_AW-1:0];
                ord_we    = 1'b1;
                ord_waddr = bkt_rdata[NODE_AW-1:0];
                ord_wdata = r_v[NODE_AW-1:0];
                bkt_we    = 1'b1;
                bkt_waddr = r_dw;
                bkt_wdata = bkt_rdata + 1'b1;
            end
            S_SH_RD: begin
                if (r_d == '0) begin
                    bkt_we    = 1'b1;
                    bkt_waddr = '0;
                end else begin
                    bkt_re    = 1'b1;
                    bkt_raddr = r_d - 1'b1;
                end
            end
            S_SH_WR: begin
                bkt_we    = 1'b1;
                bkt_waddr = r_d;
                bkt_wdata = bkt_rdata;
            end
            S_PE_U: begin
                ord_re    = (r_v != r_n);
                ord_raddr = r_v[NODE_AW-1:0];
            end
            S_PE_D: begin
                deg_re    = 1'b1;
                deg_raddr = ord_rdata;
                ast_re    = 1'b1;
                ast_raddr = NCNT_W'(ord_rdata);
            end
            S_PE_S: begin
                ast_re    = 1'b1;
                ast_raddr = NCNT_W'(r_u) + 1'b1;
            end
            S_PE_K: begin
                adj_re    = (r_k != r_kend);
                adj_raddr = r_k[ADJ_AW-1:0];
            end
            S_PE_W: begin
                deg_re    = 1'b1;
                deg_raddr = adj_rdata;
            end
            S_PE_C: begin
                pos_re    = (deg_rdata > r_du);
                pos_raddr = r_w;
                bkt_re    = (deg_rdata > r_du);
                bkt_raddr = deg_rdata;
            end
            S_PE_X: begin
                ord_re    = 1'b1;
                ord_raddr = bkt_rdata[NODE_AW-1:0];
            end
            S_PE_M: begin
                bkt_we    = 1'b1;
                bkt_waddr = r_dw;
                bkt_wdata = r_pf + 1'b1;
                deg_we    = 1'b1;
                deg_waddr = r_w;
                deg_wdata = r_dw - 1'b1;
                if (ord_rdata != r_w) begin
                    pos_we    = 1'b1;
                    pos_waddr = r_w;
                    pos_wdata = r_pf[NODE_AW-1:0];
                    ord_we    = 1'b1;
                    ord_waddr = r_pw;
                    ord_wdata = ord_rdata;
                end
            end
            S_PE_N: begin
                pos_we    = 1'b1;
                pos_waddr = r_x;
                pos_wdata = r_pw;
                ord_we    = 1'b1;
                ord_waddr = r_pf[NODE_AW-1:0];
                ord_wdata = r_w;
            end
            S_OUT_WR: begin
                cor_we    = 1'b1;
                cor_waddr = r_v[NODE_AW-1:0];
                cor_wdata = deg_rdata;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_ctl.start) begin
                        r_n     <= i_n;
                        r_et    <= i_edge_total;
                        r_v     <= '0;
                        r_state <= S_DCLR;
                    end
                end
                S_DCLR: begin
                    if (r_v == r_n) begin
                        r_e     <= '0;
                        r_mode  <= 1'b0;
                        r_state <= S_EW_RD;
                    end else begin
                        r_v <= r_v + 1'b1;
                    end
                end
                S_EW_RD: begin
                    if (r_e != r_et) begin
                        r_state <= S_EW_CHK;
                    end else if (!r_mode) begin
                        r_v      <= '0;
                        r_acc    <= '0;
                        r_maxdeg <= '0;
                        r_state  <= S_PF_RD;
                    end else begin
                        r_d     <= '0;
                        r_state <= S_BCLR;
                    end
                end
                S_EW_CHK: begin
                    r_e     <= r_e + 1'b1;
                    r_a     <= ea;
                    r_b     <= eb;
                    r_state <= e_ok ? S_EW_A : S_EW_RD;
                end
                S_EW_A: r_state <= S_EW_B;
                S_EW_B: r_state <= S_EW_RD;
                S_PF_RD: begin
                    if (r_v == r_n) begin
                        r_e     <= '0;
                        r_mode  <= 1'b1;
                        r_state <= S_EW_RD;
                    end else begin
                        r_state <= S_PF_WR;
                    end
                end
                S_PF_WR: begin
                    r_acc <= r_acc + ACC_W'(deg_rdata);
                    if (deg_rdata > r_maxdeg) begin
                        r_maxdeg <= deg_rdata;
                    end
                    r_v     <= r_v + 1'b1;
                    r_state <= S_PF_RD;
                end
                S_BCLR: begin
                    if (r_d == r_maxdeg) begin
                        r_v     <= '0;
                        r_state <= S_BC_RD;
                    end else begin
                        r_d <= r_d + 1'b1;
                    end
                end
                S_BC_RD: begin
                    if (r_v == r_n) begin
                        r_d     <= '0;
                        r_acc   <= '0;
                        r_state <= S_BS_RD;
                    end else begin
                        r_state <= S_BC_B;
                    end
                end
                S_BC_B: begin
                    r_dw    <= deg_rdata;
                    r_state <= S_BC_W;
                end
                S_BC_W: begin
                    r_v     <= r_v + 1'b1;
                    r_state <= S_BC_RD;
                end
                S_BS_RD: r_state <= S_BS_WR;
                S_BS_WR: begin
                    r_acc <= r_acc + ACC_W'(bkt_rdata);
                    if (r_d == r_maxdeg) begin
                        r_v     <= '0;
                        r_state <= S_PL_RD;
                    end else begin
                        r_d     <= r_d + 1'b1;
                        r_state <= S_BS_RD;
                    end
                end
                S_PL_RD: begin
                    if (r_v == r_n) begin
                        r_d     <= r_maxdeg;
                        r_state <= S_SH_RD;
                    end else begin
                        r_state <= S_PL_B;
                    end
                end
                S_PL_B: begin
                    r_dw    <= deg_rdata;
                    r_state <= S_PL_W;
                end
                S_PL_W: begin
                    r_v     <= r_v + 1'b1;
                    r_state <= S_PL_RD;
                end
                S_SH_RD: begin
                    if (r_d == '0) begin
                        r_v     <= '0;
                        r_state <= S_PE_U;
                    end else begin
                        r_state <= S_SH_WR;
                    end
                end
                S_SH_WR: begin
                    r_d     <= r_d - 1'b1;
                    r_state <= S_SH_RD;
                end
                S_PE_U: begin
                    if (r_v == r_n) begin
                        r_v     <= '0;
                        r_top   <= '0;
                        r_state <= S_OUT_RD;
                    end else begin
                        r_state <= S_PE_D;
                    end
                end
                S_PE_D: begin
                    r_u     <= ord_rdata;
                    r_state <= S_PE_S;
                end
                S_PE_S: begin
                    r_du    <= deg_rdata;
                    r_k     <= ast_rdata;
                    r_state <= S_PE_E;
                end
                S_PE_E: begin
                    r_kend  <= ast_rdata;
                    r_state <= S_PE_K;
                end
                S_PE_K: begin
                    if (r_k == r_kend) begin
                        r_v     <= r_v + 1'b1;
                        r_state <= S_PE_U;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_PE_W;
                    end
                end
                S_PE_W: begin
                    r_w     <= adj_rdata;
                    r_state <= S_PE_C;
                end
                S_PE_C: begin
                    r_dw    <= deg_rdata;
                    r_state <= (deg_rdata > r_du) ? S_PE_X : S_PE_K;
                end
                S_PE_X: begin
                    r_pw    <= pos_rdata;
                    r_pf    <= bkt_rdata;
                    r_state <= S_PE_M;
                end
                S_PE_M: begin
                    r_x     <= ord_rdata;
                    r_state <= (ord_rdata != r_w) ? S_PE_N : S_PE_K;
                end
                S_PE_N: r_state <= S_PE_K;
                S_OUT_RD: begin
                    r_state <= (r_v == r_n) ? S_FIN : S_OUT_WR;
                end
                S_OUT_WR: begin
                    if (deg_rdata > r_top) begin
                        r_top <= deg_rdata;
                    end
                    r_v     <= r_v + 1'b1;
                    r_state <= S_OUT_RD;
                end
                S_FIN: begin
                    if (i_ctl.res_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    gcd_ram #(.WIDTH(2 * NODE_AW), .DEPTH(MAX_EDGES), .AW(EDGE_AW)) u_edge (
        .i_clk(i_clk), .i_we(i_edge_we), .i_waddr(i_edge_waddr), .i_wdata(i_edge_wdata),
        .i_re(edg_re), .i_raddr(edg_raddr), .o_rdata(edg_rdata)
    );

    gcd_ram #(.WIDTH(DEG_W), .DEPTH(MAX_NODES), .AW(NODE_AW)) u_degree (
        .i_clk(i_clk), .i_we(deg_we), .i_waddr(deg_waddr), .i_wdata(deg_wdata),
        .i_re(deg_re), .i_raddr(deg_raddr), .o_rdata(deg_rdata)
    );

    gcd_ram #(.WIDTH(AS_W), .DEPTH(MAX_NODES + 1), .AW(NCNT_W)) u_adj_start (
        .i_clk(i_clk), .i_we(ast_we), .i_waddr(ast_waddr), .i_wdata(ast_wdata),
        .i_re(ast_re), .i_raddr(ast_raddr), .o_rdata(ast_rdata)
    );

    gcd_ram #(.WIDTH(AS_W), .DEPTH(MAX_NODES), .AW(NODE_AW)) u_fill (
        .i_clk(i_clk), .i_we(fil_we), .i_waddr(fil_waddr), .i_wdata(fil_wdata),
        .i_re(fil_re), .i_raddr(fil_raddr), .o_rdata(fil_rdata)
    );

    gcd_ram #(.WIDTH(NODE_AW), .DEPTH(2 * MAX_EDGES), .AW(ADJ_AW)) u_adj_list (
        .i_clk(i_clk), .i_we(adj_we), .i_waddr(adj_waddr), .i_wdata(adj_wdata),
        .i_re(adj_re), .i_raddr(adj_raddr), .o_rdata(adj_rdata)
    );

    gcd_ram #(.WIDTH(NODE_AW), .DEPTH(MAX_NODES), .AW(NODE_AW)) u_order (
        .i_clk(i_clk), .i_we(ord_we), .i_waddr(ord_waddr), .i_wdata(ord_wdata),
        .i_re(ord_re), .i_raddr(ord_raddr), .o_rdata(ord_rdata)
    );

    gcd_ram #(.WIDTH(NODE_AW), .DEPTH(MAX_NODES), .AW(NODE_AW)) u_position (
        .i_clk(i_clk), .i_we(pos_we), .i_waddr(pos_waddr), .i_wdata(pos_wdata),
        .i_re(pos_re), .i_raddr(pos_raddr), .o_rdata(pos_rdata)
    );

    gcd_ram #(.WIDTH(NCNT_W), .DEPTH(MAX_EDGES + 1), .AW(DEG_W)) u_bucket (
        .i_clk(i_clk), .i_we(bkt_we), .i_waddr(bkt_waddr), .i_wdata(bkt_wdata),
        .i_re(bkt_re), .i_raddr(bkt_raddr), .o_rdata(bkt_rdata)
    );

    gcd_ram #(.WIDTH(DEG_W), .DEPTH(MAX_NODES), .AW(NODE_AW)) u_coreness (
        .i_clk(i_clk), .i_we(cor_we), .i_waddr(cor_waddr), .i_wdata(cor_wdata),
        .i_re(i_core_re), .i_raddr(i_core_raddr), .o_rdata(o_core_rdata)
    );

endmodule

`default_nettype wire

// File: sim/graph_core_decomposition_test.sv
// ----------------------------------------------------------------------------
// graph_core_decomposition_test
// Self-checking bench for the k-core block: a directed table of requests,
// then random graph loads, runs, reads and clears over several node counts,
// checked transfer by transfer against a bin-sort peeling predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module graph_core_decomposition_test;
    import gcd_pkg::*;

    localparam int EDGE_CAP   = MAX_EDGES_DEF;
    localparam int NODE_CAP   = MAX_NODES_DEF;
    localparam int STALL_LIMIT = 400000;

    typedef struct packed {
        t_status         status;
        logic [9:0]      node_index;
        logic [12:0]     core_value;
    } t_result;

    typedef struct {
        bit              is_cfg;
        logic [10:0]     cfg_value;
        t_req            req;
        logic [9:0]      node_a;
        logic [9:0]      node_b;
        bit              typed;
        t_result         want;
    } t_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_W-1:0]       i_cfg_wdata = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
    logic [1:0]             s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic [1:0]             m_axis_tuser;

    graph_core_decomposition dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // node_a, node_b, pad
        .s_axis_tuser  (s_axis_tuser),   // req_type
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // node_index, core_value, pad
        .m_axis_tuser  (m_axis_tuser)    // status
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    int unsigned node_count_q = 1024;
    int unsigned edge_a [EDGE_CAP];
    int unsigned edge_b [EDGE_CAP];
    int unsigned edge_total;
    int unsigned coreness [NODE_CAP];
    int unsigned degree [NODE_CAP];
    int unsigned adj_start [NODE_CAP+1];
    int unsigned adj_list [2*EDGE_CAP];
    int unsigned order_tab [NODE_CAP];
    int unsigned pos_tab [NODE_CAP];
    int unsigned bucket [2*EDGE_CAP+1];
    int unsigned cursor [NODE_CAP];

    t_result     pending_results [$];
    int          error_count;
    int          sent_count;
    int          checked_count;
    int          run_count;
    int          idle_mode;
    int          hold_cycles;
    bit          typed_en;
    t_result     typed_want;

    function automatic int unsigned nodes_active();
        return (node_count_q > NODE_CAP) ? NODE_CAP : node_count_q;
    endfunction

    function automatic int unsigned peel_graph();
        int unsigned n, e, v, i, k, a, b, maxdeg, top, acc, c, d;
        int unsigned u, w, dw, pw, pf, x;
        n = nodes_active();
        maxdeg = 0;
        top = 0;
        for (v = 0; v < NODE_CAP; v++) degree[v] = 0;
        for (e = 0; e < edge_total; e++) begin
            a = edge_a[e];
            b = edge_b[e];
            if (a < n && b < n && a != b) begin
                degree[a]++;
                degree[b]++;
            end
        end
        adj_start[0] = 0;
        for (v = 0; v < n; v++) begin
            adj_start[v+1] = adj_start[v] + degree[v];
            cursor[v] = adj_start[v];
            if (degree[v] > maxdeg) maxdeg = degree[v];
        end
        for (e = 0; e < edge_total; e++) begin
            a = edge_a[e];
            b = edge_b[e];
            if (a < n && b < n && a != b) begin
                adj_list[cursor[a]++] = b;
                adj_list[cursor[b]++] = a;
            end
        end
        for (i = 0; i <= maxdeg; i++) bucket[i] = 0;
        for (v = 0; v < n; v++) bucket[degree[v]]++;
        acc = 0;
        for (i = 0; i <= maxdeg; i++) begin
            c = bucket[i];
            bucket[i] = acc;
            acc += c;
        end
        for (v = 0; v < n; v++) begin
            d = degree[v];
            pos_tab[v] = bucket[d];
            order_tab[bucket[d]] = v;
            bucket[d]++;
        end
        for (i = maxdeg; i > 0; i--) bucket[i] = bucket[i-1];
        bucket[0] = 0;
        for (i = 0; i < n; i++) begin
            u = order_tab[i];
            for (k = adj_start[u]; k < adj_start[u+1]; k++) begin
                w = adj_list[k];
                if (degree[w] > degree[u]) begin
                    dw = degree[w];
                    pw = pos_tab[w];
                    pf = bucket[dw];
                    x = order_tab[pf];
                    if (x != w) begin
                        pos_tab[w] = pf;
                        order_tab[pw] = x;
                        pos_tab[x] = pw;
                        order_tab[pf] = w;
                    end
                    bucket[dw]++;
                    degree[w] = dw - 1;
                end
            end
        end
        for (v = 0; v < NODE_CAP; v++) coreness[v] = 0;
        for (v = 0; v < n; v++) begin
            coreness[v] = degree[v];
            if (degree[v] > top) top = degree[v];
        end
        return top;
    endfunction

    function automatic t_result apply_request(t_req req, int unsigned a, int unsigned b);
        t_result r;
        int unsigned n, v;
        n = nodes_active();
        r = '{STS_OK, 10'd0, 13'd0};
        case (req)
            REQ_ADD_EDGE: begin
                if (a >= n || b >= n) r.status = STS_RANGE;
                else if (a == b) r.status = STS_SELF;
                else if (edge_total >= EDGE_CAP) r.status = STS_FULL;
                else begin
                    edge_a[edge_total] = a;
                    edge_b[edge_total] = b;
                    edge_total++;
                end
            end
            REQ_RUN: begin
                r.core_value = 13'(peel_graph());
                run_count++;
            end
            REQ_READ: begin
                r.node_index = 10'(a);
                if (a >= n) r.status = STS_RANGE;
                else r.core_value = 13'(coreness[a]);
            end
            default: begin
                edge_total = 0;
                for (v = 0; v < NODE_CAP; v++) begin
                    degree[v] = 0;
                    coreness[v] = 0;
                end
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want,
                 checked_count);
        error_count++;
    endtask

    // request and result transfers
    always @(posedge i_clk) begin
        t_result r, got;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = '{t_status'(m_axis_tuser), m_axis_tdata[9:0], m_axis_tdata[22:10]};
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result", 1, 0);
                end else begin
                    r = pending_results[0];
                    pending_results.delete(0);
                    if (got.status !== r.status)
                        report_mismatch("status", got.status, r.status);
                    if (got.node_index !== r.node_index)
                        report_mismatch("node_index", got.node_index, r.node_index);
                    if (got.core_value !== r.core_value)
                        report_mismatch("core_value", got.core_value, r.core_value);
                end
                checked_count++;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                r = apply_request(t_req'(s_axis_tuser), s_axis_tdata[9:0],
                                  s_axis_tdata[19:10]);
                pending_results.push_back(typed_en ? typed_want : r);
                sent_count++;
            end
        end
    end

    // watchdog on cycles with no transfer
    always @(posedge i_clk) begin
        int quiet;
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet = 0;
        else begin
            quiet++;
            if (quiet >= STALL_LIMIT) begin
                $display("timeout with %0d results pending", pending_results.size());
                $display("simulation failed");
                $finish;
            end
        end
    end

    // result side back-pressure
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            m_axis_tready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else if (idle_mode == 2)
            m_axis_tready <= ($urandom_range(99) >= 88);
        else if (idle_mode == 3)
            m_axis_tready <= ($urandom_range(99) >= 34);
        else
            m_axis_tready <= 1'b1;
    end

    task automatic send_request(t_req req, logic [9:0] a, logic [9:0] b, bit typed,
                                t_result want);
        int pct;
        pct = (idle_mode == 1) ? 88 : (idle_mode == 3) ? 34 : 0;
        while ($urandom_range(99) < pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = req;
        s_axis_tdata  = {4'd0, b, a};
        typed_en      = typed;
        typed_want    = want;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        typed_en      = 1'b0;
    endtask

    task automatic write_node_count(logic [10:0] value);
        s_axis_tvalid = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_we      = 1'b1;
        i_cfg_wdata   = value;
        node_count_q  = value;
        @(negedge i_clk);
        i_cfg_we      = 1'b0;
    endtask

    function automatic t_row mk(t_req req, int a, int b, bit typed = 0,
                                t_status st = STS_OK, int idx = 0, int core = 0);
        t_row row;
        row = '{0, 11'd0, req, a[9:0], b[9:0], typed, '{st, idx[9:0], core[12:0]}};
        return row;
    endfunction

    function automatic t_row mk_cfg(int value);
        t_row row;
        row = mk(REQ_READ, 0, 0);
        row.is_cfg = 1;
        row.cfg_value = value[10:0];
        return row;
    endfunction

    // hold: receiver stall in cycles, started once the new count is in place
    task automatic random_phase(int count, int nodes, int items, int hold = 0);
        int unsigned n, pick, a, b;
        write_node_count(count[10:0]);
        hold_cycles = hold;
        n = (nodes < 1) ? 1 : nodes;
        for (int i = 0; i < items; i++) begin
            pick = $urandom_range(99);
            a = $urandom_range(n - 1);
            b = $urandom_range(n - 1);
            if ($urandom_range(9) == 0) begin
                a = $urandom_range(1023);
                b = $urandom_range(1023);
            end
            if (pick < 60) send_request(REQ_ADD_EDGE, 10'(a), 10'(b), 1'b0, '0);
            else if (pick < 64) send_request(REQ_RUN, 10'($urandom), 10'($urandom), 1'b0, '0);
            else if (pick < 97) send_request(REQ_READ, 10'(a), 10'($urandom), 1'b0, '0);
            else send_request(REQ_CLEAR, 10'($urandom), 10'($urandom), 1'b0, '0);
        end
        send_request(REQ_RUN, 10'd0, 10'd0, 1'b0, '0);
        for (int v = 0; v < 6; v++)
            send_request(REQ_READ, 10'($urandom_range(n - 1)), 10'd0, 1'b0, '0);
    endtask

    initial begin
        t_row rows [$];
        idle_mode = 0;
        hold_cycles = 0;
        typed_en = 0;
        error_count = 0;
        edge_total = 0;
        for (int v = 0; v < NODE_CAP; v++) coreness[v] = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        rows.push_back(mk(REQ_READ, 0, 0, 1, STS_OK, 0, 0));
        rows.push_back(mk(REQ_READ, 1023, 1023, 1, STS_OK, 1023, 0));
        rows.push_back(mk(REQ_RUN, 0, 0, 1, STS_OK, 0, 0));
        rows.push_back(mk(REQ_ADD_EDGE, 0, 1023, 1, STS_OK));
        rows.push_back(mk(REQ_ADD_EDGE, 1023, 1023, 1, STS_SELF));
        rows.push_back(mk(REQ_ADD_EDGE, 1, 2));
        rows.push_back(mk(REQ_ADD_EDGE, 1, 2));     // parallel edge
        rows.push_back(mk(REQ_ADD_EDGE, 2, 0));
        rows.push_back(mk(REQ_ADD_EDGE, 1, 0));
        rows.push_back(mk(REQ_RUN, 0, 0));
        rows.push_back(mk(REQ_READ, 1, 0));
        rows.push_back(mk(REQ_READ, 1023, 0));
        rows.push_back(mk_cfg(3));                 // count lowered after loading
        rows.push_back(mk(REQ_RUN, 0, 0));
        rows.push_back(mk(REQ_READ, 3, 0, 1, STS_RANGE, 3, 0));
        rows.push_back(mk(REQ_ADD_EDGE, 3, 0, 1, STS_RANGE));
        rows.push_back(mk(REQ_ADD_EDGE, 0, 3, 1, STS_RANGE));
        rows.push_back(mk(REQ_CLEAR, 0, 0, 1, STS_OK));
        rows.push_back(mk(REQ_READ, 1, 0, 1, STS_OK, 1, 0));
        rows.push_back(mk_cfg(0));
        rows.push_back(mk(REQ_ADD_EDGE, 0, 1, 1, STS_RANGE));
        rows.push_back(mk(REQ_READ, 0, 0, 1, STS_RANGE, 0, 0));
        rows.push_back(mk(REQ_RUN, 0, 0, 1, STS_OK, 0, 0));
        rows.push_back(mk_cfg(2047));              // acts as the full count
        rows.push_back(mk(REQ_READ, 1023, 0, 1, STS_OK, 1023, 0));
        foreach (rows[i]) begin
            if (rows[i].is_cfg) write_node_count(rows[i].cfg_value);
            else send_request(rows[i].req, rows[i].node_a, rows[i].node_b,
                              rows[i].typed, rows[i].want);
        end

        idle_mode = 0; random_phase(16, 16, 140);
        idle_mode = 1; random_phase(1, 1, 80);
        idle_mode = 2; random_phase(7, 7, 150, 400);
        idle_mode = 3; random_phase(33, 33, 160);
        idle_mode = 0; random_phase(64, 64, 160);
        idle_mode = 2; random_phase(2, 2, 80);
        idle_mode = 3; random_phase(1024, 1024, 120);
        idle_mode = 1; random_phase(5, 5, 90);

        idle_mode = 0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        $display("%0d requests sent, %0d results checked, %0d decomposition runs",
                 sent_count, checked_count, run_count);
        $display("node counts 0 to 2047, parallel and self edges, clears, long output stall");
        if (error_count == 0 && pending_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
